>>> rtl/dstx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstx_pkg
// shared types, framing constants and the crc-16 ccitt byte update
// ----------------------------------------------------------------------------
package dstx_pkg;

   localparam logic [7:0]  DLE_BYTE = 8'h10;
   localparam logic [7:0]  STX_BYTE = 8'h02;
   localparam logic [7:0]  ETX_BYTE = 8'h03;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // item operations
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_PAYLOAD = 2'd1;
   localparam logic [1:0] OP_END     = 2'd2;

   // byte slot within one item, a start item has six
   localparam int SLOT_W = 3;
   localparam logic [SLOT_W-1:0] SLOT_LAST_MAX = 3'd5;

   // queued command; payload byte rides in hdr[7:0]
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] hdr;
   } cmd_type;

   // back-end status for the top level
   typedef struct packed {
      logic              busy;
      logic              esc;
      logic [SLOT_W-1:0] slot;
   } back_status_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> rtl/dstx_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstx channel interfaces
// valid/ready channels for items, output bytes and the enable register
// ----------------------------------------------------------------------------
interface dstx_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] message_type;
   logic [15:0] message_id;
   logic [7:0]  data_byte;
   modport source (output valid, operation, message_type, message_id, data_byte,
                   input ready);
   modport sink (input valid, operation, message_type, message_id, data_byte,
                 output ready);
endinterface

interface dstx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

interface dstx_csr_if;
   logic valid;
   logic ready;
   logic tx_enable;
   modport source (output valid, tx_enable, input ready);
   modport sink (input valid, tx_enable, output ready);
endinterface
`default_nettype wire

>>> rtl/dstx_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstx_queue
// small command fifo between the front and back ends
// ----------------------------------------------------------------------------
module dstx_queue #(
   parameter int DEPTH = 2
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  dstx_pkg::cmd_type    push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 out_valid,
   output dstx_pkg::cmd_type    out_data
);
   import dstx_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/dstx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstx_front
// takes items and enable writes, drops disabled or unknown items, queues the rest
// ----------------------------------------------------------------------------
module dstx_front (
   input  wire                  clock,
   input  wire                  reset,
   dstx_req_if.sink             req_if,
   dstx_csr_if.sink             csr_if,
   input  wire                  q_full,
   output logic                 q_push,
   output dstx_pkg::cmd_type    q_data
);
   import dstx_pkg::*;

   logic tx_enable_ff, tx_enable_in;
   logic known_op;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !q_full;

   assign known_op = (req_if.operation == OP_START) ||
                     (req_if.operation == OP_PAYLOAD) ||
                     (req_if.operation == OP_END);

   always_comb begin
      q_data.op  = req_if.operation;
      q_data.hdr = (req_if.operation == OP_PAYLOAD) ? {24'h0, req_if.data_byte}
                                                    : {req_if.message_type, req_if.message_id};
   end

   assign q_push = req_if.valid && !q_full && tx_enable_ff && known_op;

   assign tx_enable_in = csr_if.valid ? csr_if.tx_enable : tx_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_enable_ff <= 1'b1;
      end else begin
         tx_enable_ff <= tx_enable_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/dstx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstx_back
// byte sequencer: framing, dle stuffing, crc and the output register
// ----------------------------------------------------------------------------
module dstx_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       q_valid,
   input  dstx_pkg::cmd_type         q_data,
   output logic                      q_pop,
   dstx_rsp_if.source                rsp_if,
   output dstx_pkg::back_status_type status
);
   import dstx_pkg::*;

   cmd_type           cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              esc_ff, esc_in;
   logic [15:0]       crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [7:0] cur_byte;
   logic       stuffable, crc_en, crc_clear, slot_last;
   logic       escape, step, done;
   logic [7:0] emit_byte;
   logic       emit_last;

   // byte for the current slot
   always_comb begin
      cur_byte  = '0;
      stuffable = 1'b0;
      crc_en    = 1'b0;
      crc_clear = 1'b0;
      slot_last = 1'b0;
      case (cur_ff.op)
         OP_START: begin
            case (slot_ff)
               3'd0: begin
                  cur_byte  = DLE_BYTE;
                  crc_clear = 1'b1;
               end
               3'd1: cur_byte = STX_BYTE;
               3'd2: begin
                  cur_byte  = cur_ff.hdr[31:24];
                  stuffable = 1'b1;
                  crc_en    = 1'b1;
               end
               3'd3: begin
                  cur_byte  = cur_ff.hdr[23:16];
                  stuffable = 1'b1;
                  crc_en    = 1'b1;
               end
               3'd4: begin
                  cur_byte  = cur_ff.hdr[15:8];
                  stuffable = 1'b1;
                  crc_en    = 1'b1;
               end
               3'd5: begin
                  cur_byte  = cur_ff.hdr[7:0];
                  stuffable = 1'b1;
                  crc_en    = 1'b1;
                  slot_last = 1'b1;
               end
               default: slot_last = 1'b1;
            endcase
         end
         OP_PAYLOAD: begin
            cur_byte  = cur_ff.hdr[7:0];
            stuffable = 1'b1;
            crc_en    = 1'b1;
            slot_last = 1'b1;
         end
         OP_END: begin
            case (slot_ff)
               3'd0: begin
                  cur_byte  = crc_ff[15:8];
                  stuffable = 1'b1;
               end
               3'd1: begin
                  cur_byte  = crc_ff[7:0];
                  stuffable = 1'b1;
               end
               3'd2: cur_byte = DLE_BYTE;
               3'd3: begin
                  cur_byte  = ETX_BYTE;
                  slot_last = 1'b1;
               end
               default: slot_last = 1'b1;
            endcase
         end
         default: slot_last = 1'b1;
      endcase
   end

   assign escape    = stuffable && (cur_byte == DLE_BYTE) && !esc_ff;
   assign emit_byte = escape ? DLE_BYTE : cur_byte;
   assign emit_last = !escape && slot_last;
   assign step      = cur_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign done      = step && emit_last;
   assign q_pop     = q_valid && (!cur_valid_ff || done);

   always_comb begin
      cur_in       = q_pop ? q_data : cur_ff;
      cur_valid_in = q_pop ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      slot_in      = slot_ff;
      esc_in       = esc_ff;
      if (q_pop) begin
         slot_in = '0;
         esc_in  = 1'b0;
      end else if (step) begin
         esc_in  = escape;
         slot_in = escape ? slot_ff : slot_ff + 1'b1;
      end

      crc_in = crc_ff;
      if (step && !escape) begin
         if (crc_clear) begin
            crc_in = '0;
         end else if (crc_en) begin
            crc_in = crc_update(crc_ff, cur_byte);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         slot_ff      <= '0;
         esc_ff       <= 1'b0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         slot_ff      <= slot_in;
         esc_ff       <= esc_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_byte    = rsp_byte_ff;
   assign rsp_if.last_of_run = rsp_last_ff;

   assign status.busy = cur_valid_ff;
   assign status.esc  = esc_ff;
   assign status.slot = slot_ff;

endmodule
`default_nettype wire

>>> rtl/dle_stx_frame_transmitter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dle_stx_frame_transmitter_unit
// dle/stx/etx byte-stuffing framer with crc-16 ccitt for a byte link
//
// req_if carries packet items (start with header, payload byte, end).
// rsp_if delivers link bytes one per transfer; last_of_run marks the
// final byte an item produced. csr_if writes tx_enable; it is always ready.
// the front end accepts an item whenever the command queue has room, so
// items keep flowing while the back end or the receiver is stalled.
// when the back end is free, the first byte of an item goes from the
// command queue through the back end's item register to the output register.
// the back end emits one byte per cycle while rsp_if.ready allows it; an
// item makes payload 1 or 2 bytes, start 6 to 10, end 4 to 6.
// items that arrive while disabled, or with an unknown operation, are
// taken and dropped with no output.
// reset: queue and sequencer empty, crc zero, tx_enable set.
// when rsp_if.ready is low the output byte holds, the back end pauses, and
// the queue absorbs up to QUEUE_DEPTH items before req_if.ready drops.
// ----------------------------------------------------------------------------
module dle_stx_frame_transmitter_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire         clock,
   input  wire         reset,
   dstx_req_if.sink    req_if,
   dstx_rsp_if.source  rsp_if,
   dstx_csr_if.sink    csr_if
);
   import dstx_pkg::*;

   // front to queue
   logic            q_push;
   cmd_type         q_push_data;
   logic            q_full;
   // queue to back
   logic            q_pop;
   logic            q_valid;
   cmd_type         q_out_data;
   back_status_type back_status;

   // classifies items, holds the enable register
   dstx_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .csr_if (csr_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   // decouples the two ends
   dstx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_out_data)
   );

   // sequences framing bytes, stuffing and crc into the output register
   dstx_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_out_data),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if),
      .status  (back_status)
   );

   // a pending escape only exists inside an item in progress
   a_esc_busy : assert property (@(posedge clock) disable iff (reset)
      back_status.esc |-> back_status.busy)
      else $error("escape pending with no item in progress");

   // slot never runs past the longest item
   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> (back_status.slot <= SLOT_LAST_MAX))
      else $error("byte slot out of range");

   // the front end never writes a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full command queue");

   // an escape byte is always followed by the stuffed dle itself
   a_esc_then_dle : assert property (@(posedge clock) disable iff (reset)
      (back_status.esc && rsp_if.ready) |=> (rsp_if.valid && rsp_if.out_byte == DLE_BYTE))
      else $error("escape not followed by dle");

endmodule
`default_nettype wire
